// ----- hdl/esps_pkg.sv -----
// Shared constants, codes and control structs for the escape sequence passthrough switch.
`default_nettype none
package esps_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = $clog2(HOLD_DEPTH);

  localparam int BYTE_W     = 8;
  localparam int MIN_W      = 6;
  localparam int TMO_W      = 10;
  localparam int PAUSE_W    = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int CMP_W      = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE     = 2'd2;

  localparam logic [MIN_W-1:0]   RST_MIN_COUNT = 6'd7;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT   = 10'd500;
  localparam logic [PAUSE_W-1:0] RST_PAUSE     = 11'd1500;

  // input word kinds
  localparam logic [1:0] ACT_HOST   = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_RECV   = 2'd2;
  localparam logic [1:0] ACT_STREAM = 2'd3;

  // output destinations
  localparam logic [1:0] DEST_RECV    = 2'd0;
  localparam logic [1:0] DEST_HOST    = 2'd1;
  localparam logic [1:0] DEST_CONSOLE = 2'd2;

  localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  typedef struct packed {
    logic slot_free;     // output register empty or draining
    logic dec_single;    // word in flight yields one result
    logic dec_flush;     // word in flight starts a flush
    logic tail_pending;  // flush ends with the current byte
    logic flush_end;     // flush pointer at last held byte
  } esps_status_t;

  typedef struct packed {
    logic accept;
    logic flush_start;
    logic flush_step;
    logic tail_step;
  } esps_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/esps_ctrl.sv -----
// Controller: accepts words and sequences held-byte flushes.
`default_nettype none
module esps_ctrl import esps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  esps_status_t status,
  output esps_cmd_t    cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_FLUSH, ST_TAIL} state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE) && status.slot_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && status.slot_free) begin
          cmd.accept = 1'b1;
          if (status.dec_flush) begin
            cmd.flush_start = 1'b1;
            state_next      = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.slot_free) begin
          cmd.flush_step = 1'b1;
          if (status.flush_end) begin
            state_next = status.tail_pending ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (status.slot_free) begin
          cmd.tail_step = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/esps_datapath.sv -----
// Datapath: config registers, mode and hold state, hold buffer and output register.
`default_nettype none
module esps_datapath import esps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [BYTE_W-1:0]     s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [BYTE_W-1:0]     m_tdata,
  output logic [2:0]            m_tuser,
  output logic                  m_tlast,
  input  esps_cmd_t             cmd,
  output esps_status_t          status
);

  logic [MIN_W-1:0]   min_count;
  logic [TMO_W-1:0]   timeout;
  logic [PAUSE_W-1:0] pause_cfg;

  logic               console_mode, console_mode_next;
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic [TMO_W-1:0]   idle_elapsed, idle_elapsed_next;
  logic [PAUSE_W-1:0] pause_left, pause_left_next;
  logic               held_kinds [HOLD_DEPTH];

  logic [IDX_W-1:0]   flush_idx;
  logic               tail_pending;
  logic [BYTE_W-1:0]  tail_byte;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic [1:0]         out_dest;
  logic               out_last;
  logic               out_console;

  logic               is_esc, is_eol, has_held, full, enough;
  logic               dec_single, dec_flush, dec_tail, hold_we;
  logic [1:0]         single_dest;
  logic [CNT_W-1:0]   held_count_m1;
  logic               flush_end;

  assign is_esc   = (s_tdata == CH_PLUS) || (s_tdata == CH_EQ);
  assign is_eol   = (s_tdata == CH_CR) || (s_tdata == CH_LF);
  assign has_held = (held_count != '0);
  assign full     = (held_count == CNT_W'(HOLD_DEPTH));
  assign enough   = (CMP_W'(held_count) >= CMP_W'(min_count));

  assign held_count_m1 = held_count - 1'b1;
  assign flush_end     = (flush_idx == held_count_m1[IDX_W-1:0]);

  // decode of the word at the input and the state it leaves behind
  always_comb begin
    dec_single        = 1'b0;
    dec_flush         = 1'b0;
    dec_tail          = 1'b0;
    hold_we           = 1'b0;
    single_dest       = DEST_RECV;
    console_mode_next = console_mode;
    held_count_next   = held_count;
    idle_elapsed_next = idle_elapsed;
    pause_left_next   = pause_left;
    unique case (s_tuser)
      ACT_HOST: begin
        if (console_mode) begin
          dec_single  = 1'b1;
          single_dest = DEST_CONSOLE;
        end else begin
          if (pause_cfg > pause_left) pause_left_next = pause_cfg;
          if (is_esc && !full) begin
            hold_we           = 1'b1;
            held_count_next   = held_count + 1'b1;
            idle_elapsed_next = '0;
          end else if (is_eol && enough) begin
            held_count_next   = '0;
            idle_elapsed_next = '0;
            console_mode_next = 1'b1;
          end else if (has_held) begin
            dec_flush = 1'b1;
            dec_tail  = 1'b1;
          end else begin
            dec_single  = 1'b1;
            single_dest = DEST_RECV;
          end
        end
      end
      ACT_TICK: begin
        if (pause_left != '0) pause_left_next = pause_left - 1'b1;
        if (!console_mode && has_held) begin
          if (idle_elapsed >= timeout) dec_flush = 1'b1;
          else idle_elapsed_next = idle_elapsed + 1'b1;
        end
      end
      ACT_RECV: begin
        if (!console_mode && (pause_left == '0)) begin
          dec_single  = 1'b1;
          single_dest = DEST_HOST;
        end
      end
      ACT_STREAM: console_mode_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_count <= RST_MIN_COUNT;
      timeout   <= RST_TIMEOUT;
      pause_cfg <= RST_PAUSE;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_MIN_COUNT) min_count <= cfg_wdata[MIN_W-1:0];
      if (cfg_addr == CFG_TIMEOUT)   timeout   <= cfg_wdata[TMO_W-1:0];
      if (cfg_addr == CFG_PAUSE)     pause_cfg <= cfg_wdata[PAUSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      console_mode <= 1'b0;
      held_count   <= '0;
      idle_elapsed <= '0;
      pause_left   <= '0;
    end else if (cmd.accept) begin
      console_mode <= console_mode_next;
      held_count   <= held_count_next;
      idle_elapsed <= idle_elapsed_next;
      pause_left   <= pause_left_next;
    end else if (cmd.flush_step && flush_end) begin
      held_count   <= '0;
      idle_elapsed <= '0;
    end
  end

  // hold buffer: 1 marks '=', 0 marks '+'
  always_ff @(posedge clk) begin
    if (cmd.accept && hold_we) held_kinds[held_count[IDX_W-1:0]] <= (s_tdata == CH_EQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pending <= 1'b0;
    end else if (cmd.flush_start) begin
      tail_pending <= dec_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      flush_idx <= '0;
      tail_byte <= s_tdata;
    end else if (cmd.flush_step) begin
      flush_idx <= flush_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && dec_single) || cmd.flush_step || cmd.tail_step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && dec_single) begin
      out_byte    <= s_tdata;
      out_dest    <= single_dest;
      out_last    <= 1'b1;
      out_console <= console_mode;
    end else if (cmd.flush_step) begin
      out_byte    <= held_kinds[flush_idx] ? CH_EQ : CH_PLUS;
      out_dest    <= DEST_RECV;
      out_last    <= flush_end && !tail_pending;
      out_console <= 1'b0;
    end else if (cmd.tail_step) begin
      out_byte    <= tail_byte;
      out_dest    <= DEST_RECV;
      out_last    <= 1'b1;
      out_console <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = {out_console, out_dest};
  assign m_tlast  = out_last;

  assign status.slot_free    = !out_valid || m_tready;
  assign status.dec_single   = dec_single;
  assign status.dec_flush    = dec_flush;
  assign status.tail_pending = tail_pending;
  assign status.flush_end    = flush_end;

endmodule
`default_nettype wire

// ----- hdl/escape_sequence_passthrough_switch.sv -----
// Top level of the escape sequence passthrough switch.
// Usage:
//   Slave stream carries one word per event: s_tuser is the kind (host byte,
//   1 ms tick, receiver byte, return to stream) and s_tdata the byte.
//   Master stream carries result words: m_tdata is the byte, m_tuser gives
//   the destination (receiver, host, console) and the console-mode flag,
//   m_tlast marks the final result of an input word.
//   Config port: cfg_we with cfg_addr 0 min escape count, 1 escape timeout,
//   2 typing pause; write only while the switch is idle.
// Latency and throughput:
//   A word with a single result shows it in the cycle after acceptance; words
//   with no result or one result go at one per cycle while the receiver keeps up.
//   A flush is set up when its word is accepted, then emits the N held bytes,
//   then the current host byte if a host byte started it, all paced by the single
//   output register; the slave side is held off until the flush ends.
// Reset (rst, synchronous): stream mode, nothing held, timers clear, config
//   registers back to 7 / 500 / 1500. Hold buffer contents are not cleared.
// Receiver stall: the output register holds its word; s_tready drops until
//   the output register is free or draining in the same cycle.
`default_nettype none
module escape_sequence_passthrough_switch import esps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic [1:0]            s_tuser,   // [1:0] action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
  output logic [2:0]            m_tuser,   // [1:0] destination, [2] console_active
  output logic                  m_tlast
);

  esps_cmd_t    cmd;
  esps_status_t status;

  esps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  esps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

  // no new word is taken while a flush is emitting
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && (cmd.flush_step || cmd.tail_step)))
    else $error("word accepted during flush");

  // starting a flush closes the slave side for the next cycle
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_start |=> !s_tready)
    else $error("slave side open right after flush start");

  // console words are single results and carry the console flag
  a_console_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] == DEST_CONSOLE)) |-> (m_tlast && m_tuser[2]))
    else $error("console word without last or console flag");

  // flush words never claim console mode
  a_flush_stream: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush_step || cmd.tail_step) |=> (m_tvalid && !m_tuser[2]))
    else $error("flush word marked as console");

endmodule
`default_nettype wire
